>>> src/gsr_pkg.sv
// Shared types and codes for the 2D simplex reduction pipeline.
package gsr_pkg;

    // Vertex count codes on the input and on the result.
    localparam logic [1:0] CNT_NONE     = 2'd0;
    localparam logic [1:0] CNT_VERTEX   = 2'd1;
    localparam logic [1:0] CNT_EDGE     = 2'd2;
    localparam logic [1:0] CNT_TRIANGLE = 2'd3;

    // Original vertex codes reported in the slot fields.
    localparam logic [1:0] SRC_A = 2'd0;
    localparam logic [1:0] SRC_B = 2'd1;
    localparam logic [1:0] SRC_C = 2'd2;

    // Voronoi region that holds the query point.
    typedef enum logic [2:0] {
        REG_A,
        REG_B,
        REG_C,
        REG_AB,
        REG_BC,
        REG_CA,
        REG_ABC
    } t_region;

    // Sign tests that decide the region. A "le" flag means the weight is at most zero;
    // an "out" flag means the query lies on the outer side of that edge or on its line.
    typedef struct packed {
        logic [1:0] count;
        logic       vab_le;
        logic       uab_le;
        logic       vbc_le;
        logic       ubc_le;
        logic       vca_le;
        logic       uca_le;
        logic       ab_out;
        logic       bc_out;
        logic       ca_out;
    } t_region_flags;

endpackage

>>> src/gsr_region_select.sv
// Region decision of the simplex reduction from the weight sign tests.
module gsr_region_select
    import gsr_pkg::*;
(
    input  t_region_flags i_flags,
    output t_region       o_region
);

    // Vertex regions first, then edge regions, the full triangle last.
    always_comb begin
        o_region = REG_A;
        unique case (i_flags.count)
            CNT_EDGE: begin
                priority if (i_flags.vab_le) begin
                    o_region = REG_A;
                end else if (i_flags.uab_le) begin
                    o_region = REG_B;
                end else begin
                    o_region = REG_AB;
                end
            end
            CNT_TRIANGLE: begin
                priority if (i_flags.vab_le && i_flags.uca_le) begin
                    o_region = REG_A;
                end else if (i_flags.uab_le && i_flags.vbc_le) begin
                    o_region = REG_B;
                end else if (i_flags.ubc_le && i_flags.vca_le) begin
                    o_region = REG_C;
                end else if (!i_flags.uab_le && !i_flags.vab_le && i_flags.ab_out) begin
                    o_region = REG_AB;
                end else if (!i_flags.ubc_le && !i_flags.vbc_le && i_flags.bc_out) begin
                    o_region = REG_BC;
                end else if (!i_flags.uca_le && !i_flags.vca_le && i_flags.ca_out) begin
                    o_region = REG_CA;
                end else begin
                    o_region = REG_ABC;
                end
            end
            default: begin
                o_region = REG_A;
            end
        endcase
    end

endmodule

>>> src/gjk_simplex_reduce_2d.sv
// Top level of the 2D simplex reduction: a four-stage pipeline with stream handshakes.
//
// The slave channel takes one simplex of one to three vertices plus a query point per
// transfer. The master channel returns, per input transfer, the reduced vertex count,
// the original vertex in each slot, the unnormalised barycentric weights with their
// divisor, and the next search direction toward the origin.
// Stage 1 registers the edge and query difference vectors, stage 2 registers all
// products in parallel multipliers, stage 3 registers the dot and cross sums, and
// stage 4 decides the region and registers the selected result.
// Throughput is one item per cycle while the receiver takes results; each stage holds
// one item and advances whenever the stage after it is empty or moving.
// When the receiver stalls, items queue in the four stages and input ready drops
// once all are full; nothing is lost or repeated. A reset clears all stage valid
// bits, so the pipeline comes up empty and ready.
// Coordinates are COORD_BITS wide; the weight fields are 2*COORD_BITS+3 bits and the
// direction fields COORD_BITS+1 bits.
module gjk_simplex_reduce_2d
    import gsr_pkg::*;
#(
    parameter int COORD_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_s_axis_tvalid,
    output logic                                         o_s_axis_tready,
    // From bit 0: vertex_count, first_x, first_y, second_x, second_y, third_x,
    // third_y, query_x, query_y, then zero padding.
    input  logic [((2 + 8 * COORD_BITS + 7) / 8) * 8 - 1:0] i_s_axis_tdata,
    output logic                                         o_m_axis_tvalid,
    input  logic                                         i_m_axis_tready,
    // From bit 0: reduced_count, slot0_source, slot1_source, slot2_source, weight0,
    // weight1, weight2, weight_divisor, direction_x, direction_y, then zero padding.
    output logic [((10 * COORD_BITS + 22 + 7) / 8) * 8 - 1:0] o_m_axis_tdata
);

    localparam int C   = COORD_BITS;
    localparam int DW  = C + 1;
    localparam int W   = 2 * C + 2;
    localparam int WO  = W + 1;
    localparam int OUT_W       = 8 + 4 * WO + 2 * DW;
    localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
    localparam int NPROD = 32;
    localparam int NSUM  = 16;

    // Indexes of the stage 3 sums.
    localparam int S_UAB  = 0;
    localparam int S_VAB  = 1;
    localparam int S_UBC  = 2;
    localparam int S_VBC  = 3;
    localparam int S_UCA  = 4;
    localparam int S_VCA  = 5;
    localparam int S_AREA = 6;
    localparam int S_UT   = 7;
    localparam int S_VT   = 8;
    localparam int S_WT   = 9;
    localparam int S_DAB  = 10;
    localparam int S_DBC  = 11;
    localparam int S_DCA  = 12;
    localparam int S_SAB  = 13;
    localparam int S_SBC  = 14;
    localparam int S_SCA  = 15;

    function automatic logic signed [DW-1:0] sx(input logic signed [C-1:0] v);
        return {v[C-1], v};
    endfunction

    function automatic logic le0(input logic signed [W-1:0] v);
        return v[W-1] | (v == '0);
    endfunction

    function automatic logic signed [WO-1:0] wx(input logic signed [W-1:0] v);
        return {v[W-1], v};
    endfunction

    // Edge normal on the origin side; pos is set when the origin lies left of the edge.
    function automatic logic [2*DW-1:0] edge_dir(input logic signed [DW-1:0] ex,
                                                 input logic signed [DW-1:0] ey,
                                                 input logic pos);
        logic signed [DW-1:0] dx;
        logic signed [DW-1:0] dy;
        if (pos) begin
            dx = -ey;
            dy = ex;
        end else begin
            dx = ey;
            dy = -ex;
        end
        return {dy, dx};
    endfunction

    // Stage handshake: a stage loads when it is empty or its contents move on.
    logic r1_valid, r2_valid, r3_valid, r4_valid;
    logic en1, en2, en3, en4;

    assign en4 = !r4_valid || i_m_axis_tready;
    assign en3 = !r3_valid || en4;
    assign en2 = !r2_valid || en3;
    assign en1 = !r1_valid || en2;
    assign o_s_axis_tready = en1;
    assign o_m_axis_tvalid = r4_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else begin
            if (en1) r1_valid <= i_s_axis_tvalid;
            if (en2) r2_valid <= r1_valid;
            if (en3) r3_valid <= r2_valid;
            if (en4) r4_valid <= r3_valid;
        end
    end

    // Input field unpacking.
    logic [1:0]          in_cnt;
    logic signed [C-1:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy, in_qx, in_qy;

    assign in_cnt = i_s_axis_tdata[1:0];
    assign in_ax  = i_s_axis_tdata[2 + 0 * C +: C];
    assign in_ay  = i_s_axis_tdata[2 + 1 * C +: C];
    assign in_bx  = i_s_axis_tdata[2 + 2 * C +: C];
    assign in_by  = i_s_axis_tdata[2 + 3 * C +: C];
    assign in_cx  = i_s_axis_tdata[2 + 4 * C +: C];
    assign in_cy  = i_s_axis_tdata[2 + 5 * C +: C];
    assign in_qx  = i_s_axis_tdata[2 + 6 * C +: C];
    assign in_qy  = i_s_axis_tdata[2 + 7 * C +: C];

    // Stage 1: difference vectors of the query to each vertex and along each edge.
    logic [1:0]           r1_cnt;
    logic signed [C-1:0]  r1_ax, r1_ay, r1_bx, r1_by, r1_cx, r1_cy;
    logic signed [DW-1:0] r1_qax, r1_qay, r1_qbx, r1_qby, r1_qcx, r1_qcy;
    logic signed [DW-1:0] r1_eabx, r1_eaby, r1_ebcx, r1_ebcy, r1_ecax, r1_ecay;

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_cnt  <= (in_cnt == CNT_NONE) ? CNT_VERTEX : in_cnt;
            r1_ax   <= in_ax;
            r1_ay   <= in_ay;
            r1_bx   <= in_bx;
            r1_by   <= in_by;
            r1_cx   <= in_cx;
            r1_cy   <= in_cy;
            r1_qax  <= sx(in_qx) - sx(in_ax);
            r1_qay  <= sx(in_qy) - sx(in_ay);
            r1_qbx  <= sx(in_qx) - sx(in_bx);
            r1_qby  <= sx(in_qy) - sx(in_by);
            r1_qcx  <= sx(in_qx) - sx(in_cx);
            r1_qcy  <= sx(in_qy) - sx(in_cy);
            r1_eabx <= sx(in_bx) - sx(in_ax);
            r1_eaby <= sx(in_by) - sx(in_ay);
            r1_ebcx <= sx(in_cx) - sx(in_bx);
            r1_ebcy <= sx(in_cy) - sx(in_by);
            r1_ecax <= sx(in_ax) - sx(in_cx);
            r1_ecay <= sx(in_ay) - sx(in_cy);
        end
    end

    // Multiplier operand routing: each pair of products forms one dot or cross term.
    logic signed [DW-1:0] m_a [NPROD];
    logic signed [DW-1:0] m_b [NPROD];

    always_comb begin
        m_a[0]  = r1_qbx;      m_b[0]  = r1_eabx;
        m_a[1]  = r1_qby;      m_b[1]  = r1_eaby;
        m_a[2]  = r1_qax;      m_b[2]  = r1_eabx;
        m_a[3]  = r1_qay;      m_b[3]  = r1_eaby;
        m_a[4]  = r1_qcx;      m_b[4]  = r1_ebcx;
        m_a[5]  = r1_qcy;      m_b[5]  = r1_ebcy;
        m_a[6]  = r1_qbx;      m_b[6]  = r1_ebcx;
        m_a[7]  = r1_qby;      m_b[7]  = r1_ebcy;
        m_a[8]  = r1_qax;      m_b[8]  = r1_ecax;
        m_a[9]  = r1_qay;      m_b[9]  = r1_ecay;
        m_a[10] = r1_qcx;      m_b[10] = r1_ecax;
        m_a[11] = r1_qcy;      m_b[11] = r1_ecay;
        m_a[12] = r1_eaby;     m_b[12] = r1_ecax;
        m_a[13] = r1_eabx;     m_b[13] = r1_ecay;
        m_a[14] = r1_qbx;      m_b[14] = r1_qcy;
        m_a[15] = r1_qby;      m_b[15] = r1_qcx;
        m_a[16] = r1_qcx;      m_b[16] = r1_qay;
        m_a[17] = r1_qcy;      m_b[17] = r1_qax;
        m_a[18] = r1_qax;      m_b[18] = r1_qby;
        m_a[19] = r1_qay;      m_b[19] = r1_qbx;
        m_a[20] = r1_eabx;     m_b[20] = r1_eabx;
        m_a[21] = r1_eaby;     m_b[21] = r1_eaby;
        m_a[22] = r1_ebcx;     m_b[22] = r1_ebcx;
        m_a[23] = r1_ebcy;     m_b[23] = r1_ebcy;
        m_a[24] = r1_ecax;     m_b[24] = r1_ecax;
        m_a[25] = r1_ecay;     m_b[25] = r1_ecay;
        m_a[26] = r1_eaby;     m_b[26] = sx(r1_ax);
        m_a[27] = r1_eabx;     m_b[27] = sx(r1_ay);
        m_a[28] = r1_ebcy;     m_b[28] = sx(r1_bx);
        m_a[29] = r1_ebcx;     m_b[29] = sx(r1_by);
        m_a[30] = r1_ecay;     m_b[30] = sx(r1_cx);
        m_a[31] = r1_ecax;     m_b[31] = sx(r1_cy);
    end

    // Stage 2: all products in parallel, with the vertices and edges carried along.
    logic signed [W-1:0]  r2_prod [NPROD];
    logic [1:0]           r2_cnt;
    logic signed [C-1:0]  r2_ax, r2_ay, r2_bx, r2_by, r2_cx, r2_cy;
    logic signed [DW-1:0] r2_eabx, r2_eaby, r2_ebcx, r2_ebcy, r2_ecax, r2_ecay;

    always_ff @(posedge i_clk) begin
        if (en2) begin
            for (int k = 0; k < NPROD; k++) begin
                r2_prod[k] <= m_a[k] * m_b[k];
            end
            r2_cnt  <= r1_cnt;
            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_bx   <= r1_bx;
            r2_by   <= r1_by;
            r2_cx   <= r1_cx;
            r2_cy   <= r1_cy;
            r2_eabx <= r1_eabx;
            r2_eaby <= r1_eaby;
            r2_ebcx <= r1_ebcx;
            r2_ebcy <= r1_ebcy;
            r2_ecax <= r1_ecax;
            r2_ecay <= r1_ecay;
        end
    end

    // Stage 3: dot products, cross products and squared edge lengths.
    logic signed [W-1:0]  r3_sum [NSUM];
    logic [1:0]           r3_cnt;
    logic signed [C-1:0]  r3_ax, r3_ay, r3_bx, r3_by, r3_cx, r3_cy;
    logic signed [DW-1:0] r3_eabx, r3_eaby, r3_ebcx, r3_ebcy, r3_ecax, r3_ecay;

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r3_sum[S_UAB]  <= -(r2_prod[0] + r2_prod[1]);
            r3_sum[S_VAB]  <= r2_prod[2] + r2_prod[3];
            r3_sum[S_UBC]  <= -(r2_prod[4] + r2_prod[5]);
            r3_sum[S_VBC]  <= r2_prod[6] + r2_prod[7];
            r3_sum[S_UCA]  <= -(r2_prod[8] + r2_prod[9]);
            r3_sum[S_VCA]  <= r2_prod[10] + r2_prod[11];
            r3_sum[S_AREA] <= r2_prod[12] - r2_prod[13];
            r3_sum[S_UT]   <= r2_prod[14] - r2_prod[15];
            r3_sum[S_VT]   <= r2_prod[16] - r2_prod[17];
            r3_sum[S_WT]   <= r2_prod[18] - r2_prod[19];
            r3_sum[S_DAB]  <= r2_prod[20] + r2_prod[21];
            r3_sum[S_DBC]  <= r2_prod[22] + r2_prod[23];
            r3_sum[S_DCA]  <= r2_prod[24] + r2_prod[25];
            r3_sum[S_SAB]  <= r2_prod[26] - r2_prod[27];
            r3_sum[S_SBC]  <= r2_prod[28] - r2_prod[29];
            r3_sum[S_SCA]  <= r2_prod[30] - r2_prod[31];
            r3_cnt  <= r2_cnt;
            r3_ax   <= r2_ax;
            r3_ay   <= r2_ay;
            r3_bx   <= r2_bx;
            r3_by   <= r2_by;
            r3_cx   <= r2_cx;
            r3_cy   <= r2_cy;
            r3_eabx <= r2_eabx;
            r3_eaby <= r2_eaby;
            r3_ebcx <= r2_ebcx;
            r3_ebcy <= r2_ebcy;
            r3_ecax <= r2_ecax;
            r3_ecay <= r2_ecay;
        end
    end

    // Stage 4 sign tests. An edge is "out" when the signed area and the opposite
    // sub-area do not share a strict sign.
    t_region_flags flags;
    t_region       region;
    logic          area_zero;
    logic          area_neg;

    assign area_zero = (r3_sum[S_AREA] == '0);
    assign area_neg  = r3_sum[S_AREA][W-1];

    always_comb begin
        flags.count  = r3_cnt;
        flags.vab_le = le0(r3_sum[S_VAB]);
        flags.uab_le = le0(r3_sum[S_UAB]);
        flags.vbc_le = le0(r3_sum[S_VBC]);
        flags.ubc_le = le0(r3_sum[S_UBC]);
        flags.vca_le = le0(r3_sum[S_VCA]);
        flags.uca_le = le0(r3_sum[S_UCA]);
        flags.ab_out = area_zero || (r3_sum[S_WT] == '0)
                       || (area_neg ^ r3_sum[S_WT][W-1]);
        flags.bc_out = area_zero || (r3_sum[S_UT] == '0)
                       || (area_neg ^ r3_sum[S_UT][W-1]);
        flags.ca_out = area_zero || (r3_sum[S_VT] == '0)
                       || (area_neg ^ r3_sum[S_VT][W-1]);
    end

    gsr_region_select u_region_select (
        .i_flags  (flags),
        .o_region (region)
    );

    // Result selection for the chosen region.
    logic [1:0]           n_count, n_src0, n_src1, n_src2;
    logic signed [WO-1:0] n_w0, n_w1, n_w2, n_div;
    logic signed [DW-1:0] n_dir_x, n_dir_y;

    always_comb begin
        n_count = CNT_VERTEX;
        n_src0  = SRC_A;
        n_src1  = SRC_A;
        n_src2  = SRC_A;
        n_w0    = WO'(1);
        n_w1    = '0;
        n_w2    = '0;
        n_div   = WO'(1);
        n_dir_x = -sx(r3_ax);
        n_dir_y = -sx(r3_ay);
        unique case (region)
            REG_A: begin
                n_src0  = SRC_A;
                n_dir_x = -sx(r3_ax);
                n_dir_y = -sx(r3_ay);
            end
            REG_B: begin
                n_src0  = SRC_B;
                n_dir_x = -sx(r3_bx);
                n_dir_y = -sx(r3_by);
            end
            REG_C: begin
                n_src0  = SRC_C;
                n_dir_x = -sx(r3_cx);
                n_dir_y = -sx(r3_cy);
            end
            REG_AB: begin
                n_count = CNT_EDGE;
                n_src0  = SRC_A;
                n_src1  = SRC_B;
                n_w0    = wx(r3_sum[S_UAB]);
                n_w1    = wx(r3_sum[S_VAB]);
                n_div   = wx(r3_sum[S_DAB]);
                {n_dir_y, n_dir_x} = edge_dir(r3_eabx, r3_eaby, !le0(r3_sum[S_SAB]));
            end
            REG_BC: begin
                n_count = CNT_EDGE;
                n_src0  = SRC_B;
                n_src1  = SRC_C;
                n_w0    = wx(r3_sum[S_UBC]);
                n_w1    = wx(r3_sum[S_VBC]);
                n_div   = wx(r3_sum[S_DBC]);
                {n_dir_y, n_dir_x} = edge_dir(r3_ebcx, r3_ebcy, !le0(r3_sum[S_SBC]));
            end
            REG_CA: begin
                n_count = CNT_EDGE;
                n_src0  = SRC_C;
                n_src1  = SRC_A;
                n_w0    = wx(r3_sum[S_UCA]);
                n_w1    = wx(r3_sum[S_VCA]);
                n_div   = wx(r3_sum[S_DCA]);
                {n_dir_y, n_dir_x} = edge_dir(r3_ecax, r3_ecay, !le0(r3_sum[S_SCA]));
            end
            REG_ABC: begin
                n_count = CNT_TRIANGLE;
                n_src0  = SRC_A;
                n_src1  = SRC_B;
                n_src2  = SRC_C;
                n_w0    = wx(r3_sum[S_UT]);
                n_w1    = wx(r3_sum[S_VT]);
                n_w2    = wx(r3_sum[S_WT]);
                n_div   = wx(r3_sum[S_AREA]);
                n_dir_x = '0;
                n_dir_y = '0;
            end
            default: begin
                n_count = CNT_VERTEX;
            end
        endcase
    end

    // Stage 4 output register.
    logic [1:0]           r4_count, r4_src0, r4_src1, r4_src2;
    logic signed [WO-1:0] r4_w0, r4_w1, r4_w2, r4_div;
    logic signed [DW-1:0] r4_dir_x, r4_dir_y;

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r4_count <= n_count;
            r4_src0  <= n_src0;
            r4_src1  <= n_src1;
            r4_src2  <= n_src2;
            r4_w0    <= n_w0;
            r4_w1    <= n_w1;
            r4_w2    <= n_w2;
            r4_div   <= n_div;
            r4_dir_x <= n_dir_x;
            r4_dir_y <= n_dir_y;
        end
    end

    // Result packing, first field in the lowest bits, zero padded to whole bytes.
    logic [OUT_W-1:0] out_fields;

    assign out_fields = {r4_dir_y, r4_dir_x, r4_div, r4_w2, r4_w1, r4_w0,
                         r4_src2, r4_src1, r4_src0, r4_count};
    assign o_m_axis_tdata = OUT_TDATA_W'(out_fields);

endmodule
